// ===== sv/icmp_pkg.sv =====
// Shared types, constants and a checksum helper for the ICMP echo responder.
package icmp_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [31:0] addr_t;
  typedef logic [31:0] sum_t;
  typedef logic [2:0]  verdict_t;

  localparam word_t HDR_LEN         = 16'd8;
  localparam word_t COUNT_MAX       = 16'hFFFF;
  localparam word_t REPLY_ZERO_LEN  = 16'd4;
  localparam word_t SEQ_HI_OFFSET   = 16'd6;
  localparam word_t SEQ_LO_OFFSET   = 16'd7;
  localparam byte_t TYPE_ECHO_REPLY   = 8'd0;
  localparam byte_t TYPE_ECHO_REQUEST = 8'd8;

  localparam verdict_t VERDICT_PENDING   = 3'd0;
  localparam verdict_t VERDICT_SHORT     = 3'd1;
  localparam verdict_t VERDICT_BAD_CSUM  = 3'd2;
  localparam verdict_t VERDICT_REQUEST   = 3'd3;
  localparam verdict_t VERDICT_REPLY     = 3'd4;
  localparam verdict_t VERDICT_OTHER     = 3'd5;

  // Fold a 32-bit word sum to 16 bits with end-around carry, then complement.
  // Two folds always suffice: the first leaves at most 17'h1FFFE.
  function automatic word_t fold_complement(input sum_t s);
    logic [16:0] t1;
    word_t       t2;
    t1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    t2 = t1[15:0] + {15'd0, t1[16]};
    return ~t2;
  endfunction

endpackage

// ===== sv/icmp_if.sv =====
// Valid/ready channel interfaces for message bytes in and reply results out.
interface icmp_in_if;
  logic                valid;
  logic                ready;
  icmp_pkg::byte_t     data_byte;
  logic                last;
  icmp_pkg::addr_t     src_addr;

  modport source (output valid, output data_byte, output last, output src_addr,
                  input ready);
  modport sink   (input valid, input data_byte, input last, input src_addr,
                  output ready);
endinterface

interface icmp_out_if;
  logic                  valid;
  logic                  ready;
  icmp_pkg::byte_t       reply_byte;
  logic                  end_of_message;
  icmp_pkg::verdict_t    verdict;
  icmp_pkg::word_t       reply_checksum;
  icmp_pkg::word_t       echo_seq;
  icmp_pkg::addr_t       dest_addr;

  modport source (output valid, output reply_byte, output end_of_message,
                  output verdict, output reply_checksum, output echo_seq,
                  output dest_addr, input ready);
  modport sink   (input valid, input reply_byte, input end_of_message,
                  input verdict, input reply_checksum, input echo_seq,
                  input dest_addr, output ready);
endinterface

// ===== sv/icmp_echo_responder.sv =====
// ICMP echo responder: one message byte in, one reply-image byte out per item.
// Each item passes an input register and a result register, so the block
// takes one byte per cycle while the result is not stalled; the per-message
// word sums, byte count and header fields update as an item leaves the input
// register, and the checksum fold on the last byte sits in that same step.
// The reply image zeroes offsets 0 to 3 and copies the rest. On the last byte
// the result carries the verdict, for an echo request the reply checksum and
// destination address, for an echo reply the sequence; all per-message state
// then clears for the next message. Byte offsets saturate at 65535.
module icmp_echo_responder (
  input  logic           clk,
  input  logic           rst_n,
  icmp_in_if.sink        in_ch,
  icmp_out_if.source     out_ch
);

  logic                  in_vld_r;
  icmp_pkg::byte_t       in_byte_r;
  logic                  in_last_r;
  icmp_pkg::addr_t       in_src_r;

  logic                  out_vld_r;
  icmp_pkg::byte_t       out_byte_r;
  logic                  out_eom_r;
  icmp_pkg::verdict_t    out_verdict_r;
  icmp_pkg::word_t       out_csum_r;
  icmp_pkg::word_t       out_seq_r;
  icmp_pkg::addr_t       out_dest_r;

  icmp_pkg::word_t       byte_count_r, byte_count_nxt;
  icmp_pkg::sum_t        input_sum_r, input_sum_nxt;
  icmp_pkg::sum_t        reply_sum_r, reply_sum_nxt;
  icmp_pkg::byte_t       held_high_r, held_high_nxt;
  icmp_pkg::byte_t       msg_type_r, msg_type_nxt;
  icmp_pkg::word_t       seq_field_r, seq_field_nxt;

  icmp_pkg::byte_t       reply_byte;
  icmp_pkg::verdict_t    verdict;
  icmp_pkg::word_t       reply_csum;
  icmp_pkg::word_t       echo_seq;
  icmp_pkg::addr_t       dest_addr;
  logic                  hdr_zero;
  logic                  advance;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_comb begin
    hdr_zero       = byte_count_r < icmp_pkg::REPLY_ZERO_LEN;
    reply_byte     = hdr_zero ? 8'd0 : in_byte_r;
    msg_type_nxt   = msg_type_r;
    seq_field_nxt  = seq_field_r;
    held_high_nxt  = held_high_r;
    input_sum_nxt  = input_sum_r;
    reply_sum_nxt  = reply_sum_r;
    byte_count_nxt = byte_count_r;

    if (byte_count_r == 16'd0) begin
      msg_type_nxt = in_byte_r;
    end else if (byte_count_r == icmp_pkg::SEQ_HI_OFFSET) begin
      seq_field_nxt = {in_byte_r, seq_field_r[7:0]};
    end else if (byte_count_r == icmp_pkg::SEQ_LO_OFFSET) begin
      seq_field_nxt = {seq_field_r[15:8], in_byte_r};
    end

    if (!byte_count_r[0]) begin
      held_high_nxt = in_byte_r;
      // pad a trailing odd byte with a low zero
      if (in_last_r) begin
        input_sum_nxt = input_sum_r + {16'd0, in_byte_r, 8'd0};
        reply_sum_nxt = reply_sum_r + {16'd0, reply_byte, 8'd0};
      end
    end else begin
      input_sum_nxt = input_sum_r + {16'd0, held_high_r, in_byte_r};
      reply_sum_nxt = reply_sum_r + {16'd0, (hdr_zero ? 8'd0 : held_high_r), reply_byte};
    end

    if (byte_count_r != icmp_pkg::COUNT_MAX) begin
      byte_count_nxt = byte_count_r + 16'd1;
    end

    verdict    = icmp_pkg::VERDICT_PENDING;
    reply_csum = 16'd0;
    echo_seq   = 16'd0;
    dest_addr  = 32'd0;
    if (in_last_r) begin
      if (byte_count_nxt < icmp_pkg::HDR_LEN) begin
        verdict = icmp_pkg::VERDICT_SHORT;
      end else if (icmp_pkg::fold_complement(input_sum_nxt) != 16'd0) begin
        verdict = icmp_pkg::VERDICT_BAD_CSUM;
      end else if (msg_type_nxt == icmp_pkg::TYPE_ECHO_REQUEST) begin
        verdict    = icmp_pkg::VERDICT_REQUEST;
        reply_csum = icmp_pkg::fold_complement(reply_sum_nxt);
        dest_addr  = in_src_r;
      end else if (msg_type_nxt == icmp_pkg::TYPE_ECHO_REPLY) begin
        verdict  = icmp_pkg::VERDICT_REPLY;
        echo_seq = seq_field_nxt;
      end else begin
        verdict = icmp_pkg::VERDICT_OTHER;
      end
      // clear per-message state for the next message
      msg_type_nxt   = 8'd0;
      seq_field_nxt  = 16'd0;
      held_high_nxt  = 8'd0;
      input_sum_nxt  = 32'd0;
      reply_sum_nxt  = 32'd0;
      byte_count_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      byte_count_r <= 16'd0;
      input_sum_r  <= 32'd0;
      reply_sum_r  <= 32'd0;
      held_high_r  <= 8'd0;
      msg_type_r   <= 8'd0;
      seq_field_r  <= 16'd0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r    <= 1'b1;
        byte_count_r <= byte_count_nxt;
        input_sum_r  <= input_sum_nxt;
        reply_sum_r  <= reply_sum_nxt;
        held_high_r  <= held_high_nxt;
        msg_type_r   <= msg_type_nxt;
        seq_field_r  <= seq_field_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers: input loads on accept, result on advance, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last;
      in_src_r  <= in_ch.src_addr;
    end
    if (advance) begin
      out_byte_r    <= reply_byte;
      out_eom_r     <= in_last_r;
      out_verdict_r <= verdict;
      out_csum_r    <= reply_csum;
      out_seq_r     <= echo_seq;
      out_dest_r    <= dest_addr;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.reply_byte     = out_byte_r;
  assign out_ch.end_of_message = out_eom_r;
  assign out_ch.verdict        = out_verdict_r;
  assign out_ch.reply_checksum = out_csum_r;
  assign out_ch.echo_seq       = out_seq_r;
  assign out_ch.dest_addr      = out_dest_r;

`ifndef SYNTHESIS
  a_verdict_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_eom_r |-> out_verdict_r == icmp_pkg::VERDICT_PENDING)
    else $error("verdict reported on a non-final item");

  a_dest_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_verdict_r != icmp_pkg::VERDICT_REQUEST |-> out_dest_r == 32'd0)
    else $error("destination address set without an answered request");

  a_state_clears_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |=> byte_count_r == 16'd0 && input_sum_r == 32'd0)
    else $error("message state not cleared after final byte");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> $stable(byte_count_r) && $stable(input_sum_r))
    else $error("message state advanced while the result stalls");
`endif

endmodule
